FILE: rtl/core/icfmix_pkg.sv
package icfmix_pkg;

    // Video levels and the full-scale contribution factor.
    localparam logic [7:0] BLACK_LEVEL = 8'd16;
    localparam logic [7:0] CHAN_MAX    = 8'd255;
    localparam int unsigned ICF_FULL   = 63;

    // Division by ICF_FULL: floor(m / 63) == (m * RECIP_MUL) >> RECIP_SHIFT for m < 2^14.
    localparam int unsigned RECIP_SHIFT = 20;
    localparam logic [14:0] RECIP_MUL   = 15'(((1 << RECIP_SHIFT) + ICF_FULL - 1) / ICF_FULL);

    // Field widths of one request and one result.
    localparam int unsigned PIXEL_W    = 32;
    localparam int unsigned RGB_W      = 24;
    localparam int unsigned ICF_W      = 6;
    localparam int unsigned IN_BITS    = 2 * PIXEL_W + 2 * ICF_W + RGB_W;
    localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_TDATA_W = ((RGB_W + 7) / 8) * 8;

    // One input request, already unpacked.
    typedef struct packed {
        logic [RGB_W-1:0]   backdrop_rgb;
        logic [ICF_W-1:0]   back_icf;
        logic [ICF_W-1:0]   front_icf;
        logic [PIXEL_W-1:0] back_pixel;
        logic [PIXEL_W-1:0] front_pixel;
    } pix_req_t;

    // Scale one channel: (c - 16) * icf / 63 + 16, quotient truncated toward zero.
    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [ICF_W-1:0] icf);
        logic signed [8:0]  d;
        logic signed [15:0] p;
        logic               neg;
        logic [15:0]        p_abs;
        logic [13:0]        m;
        logic [28:0]        prod;
        logic [8:0]         q;
        logic [8:0]         s;
        d     = $signed({1'b0, c}) - $signed({1'b0, BLACK_LEVEL});
        p     = 16'(d) * $signed({10'd0, icf});
        neg   = p[15];
        p_abs = neg ? 16'(-p) : 16'(p);
        m     = p_abs[13:0];
        // Shift-and-add form of the reciprocal multiply.
        prod  = ({15'd0, m} << 14) + ({15'd0, m} << 8) + ({15'd0, m} << 2) + {15'd0, m};
        q     = prod[28:RECIP_SHIFT];
        s     = neg ? ({1'b0, BLACK_LEVEL} - q) : ({1'b0, BLACK_LEVEL} + q);
        return s[7:0];
    endfunction

    // Add two scaled channels less the black level, clamped to 0..255.
    function automatic logic [7:0] mix_chan(input logic [7:0] f, input logic [7:0] b);
        logic signed [10:0] v;
        logic [7:0]         r;
        v = $signed({3'd0, f}) + $signed({3'd0, b}) - $signed({3'd0, BLACK_LEVEL});
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > $signed({3'd0, CHAN_MAX}))
        begin
            r = CHAN_MAX;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/icf_plane_overlay_mix_top.sv
// Plane overlay and mix with per-plane contribution factor scaling.
//
// Input stream (s_axis_*): one request per pixel carrying the front and back
// plane pixels, a contribution factor for each plane and the backdrop color.
// Output stream (m_axis_*): one opaque RGB screen pixel per request, in order.
// Configuration: cfg_wr_en writes cfg_wr_data into the mix enable register;
// write it only while no request is in flight.
//
// The block is a two-register pipeline: an input register, then the scaling
// and selection logic, then the result register. A request accepted into the
// input register moves on to the result register, which drives m_axis_tvalid,
// when that register is empty or being read. Throughput is one pixel per clock
// as long as the receiver takes results.
//
// Reset clears both pipeline valid flags and selects overlay mode. When the
// receiver stalls, the result register holds its pixel, and the input
// register keeps one more request, after which s_axis_tready drops.
module icf_plane_overlay_mix_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, lowest bit up: front_pixel[31:0], back_pixel[31:0], front_icf[5:0],
    // back_icf[5:0], backdrop_rgb[23:0], zero pad[3:0].
    input  logic [icfmix_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata, lowest bit up: screen_rgb[23:0].
    output logic [icfmix_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration.
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_wr_data
);

    logic                                  mix_enable_reg;
    logic                                  in_valid_reg;
    icfmix_pkg::pix_req_t                  in_data_reg;
    logic                                  out_valid_reg;
    logic [icfmix_pkg::RGB_W-1:0]          out_rgb_reg;
    logic [icfmix_pkg::RGB_W-1:0]          out_rgb_next;
    logic                                  advance;
    logic                                  front_vis;
    logic                                  back_vis;
    logic [icfmix_pkg::RGB_W-1:0]          front_scaled;
    logic [icfmix_pkg::RGB_W-1:0]          back_scaled;
    logic [icfmix_pkg::RGB_W-1:0]          mixed;

    // Pipeline flow control.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // Mix enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mix_enable_reg <= cfg_wr_data;
        end
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= icfmix_pkg::pix_req_t'(s_axis_tdata[icfmix_pkg::IN_BITS-1:0]);
        end
    end

    // Visibility from the alpha bytes.
    assign front_vis = |in_data_reg.front_pixel[31:24];
    assign back_vis  = |in_data_reg.back_pixel[31:24];

    // Per-channel scaling and mixing.
    genvar ch;
    generate
        for (ch = 0; ch < 3; ch++)
        begin : g_chan
            assign front_scaled[ch*8 +: 8] =
                icfmix_pkg::scale_chan(in_data_reg.front_pixel[ch*8 +: 8], in_data_reg.front_icf);
            assign back_scaled[ch*8 +: 8] =
                icfmix_pkg::scale_chan(in_data_reg.back_pixel[ch*8 +: 8], in_data_reg.back_icf);
            assign mixed[ch*8 +: 8] =
                icfmix_pkg::mix_chan(front_scaled[ch*8 +: 8], back_scaled[ch*8 +: 8]);
        end
    endgenerate

    // Plane selection.
    always_comb
    begin
        if (mix_enable_reg && front_vis && back_vis)
        begin
            out_rgb_next = mixed;
        end
        else if (front_vis)
        begin
            out_rgb_next = front_scaled;
        end
        else if (back_vis)
        begin
            out_rgb_next = back_scaled;
        end
        else
        begin
            out_rgb_next = in_data_reg.backdrop_rgb;
        end
    end

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_rgb_reg <= out_rgb_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(icfmix_pkg::OUT_TDATA_W - icfmix_pkg::RGB_W){1'b0}}, out_rgb_reg};

    // The input side only blocks when both stages are full and the receiver stalls.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while the pipeline has room");

    // A held request in the input register is not lost or changed.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input register changed while stalled");

    // A request in the input register moves to the result register when it advances.
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("request dropped between stages");

    // An accepted request always lands in the input register.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted request not captured");

endmodule
